/* rtl/ccds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccds_pkg
// Shared types, constants and helpers of the character class DFA step core.
// ----------------------------------------------------------------------------
package ccds_pkg;

	localparam int NUM_STATES      = 16;
	localparam int SLOTS_PER_STATE = 8;
	localparam int NUM_CLASSES     = 98;

	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int SLOT_W  = $clog2(SLOTS_PER_STATE);
	localparam int CNT_W   = $clog2(SLOTS_PER_STATE + 1);
	localparam int CLASS_W = $clog2(NUM_CLASSES);
	localparam int CADDR_W = STATE_W + CLASS_W;

	localparam logic [CLASS_W-1:0] CLASS_CR = CLASS_W'(NUM_CLASSES - 2);
	localparam logic [CLASS_W-1:0] CLASS_LF = CLASS_W'(NUM_CLASSES - 1);

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_DEL   = 8'd127;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;

	// Operation codes carried in s_tuser.
	localparam logic [2:0] OP_BYTE    = 3'd0;
	localparam logic [2:0] OP_FORCE   = 3'd1;
	localparam logic [2:0] OP_WCLASS  = 3'd2;
	localparam logic [2:0] OP_WTARGET = 3'd3;
	localparam logic [2:0] OP_WCOUNT  = 3'd4;
	localparam logic [2:0] OP_RESTART = 3'd5;

	// Result status codes carried in m_tuser.
	localparam logic [1:0] ST_MATCH   = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	// Configuration register indexes (byte address / 4).
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_ERROR = 2'd1;
	localparam logic [1:0] REG_FINAL = 2'd2;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef logic [SLOTS_PER_STATE-1:0][STATE_W-1:0] tgt_row_t;

	typedef struct packed {
		logic                       en;
		logic [CADDR_W-1:0]         addr;
		logic [SLOTS_PER_STATE-1:0] data;
	} cmem_wr_t;

	typedef struct packed {
		logic               en;
		logic [STATE_W-1:0] row;
		logic [SLOT_W-1:0]  slot;
		logic [STATE_W-1:0] data;
	} tmem_wr_t;

	typedef struct packed {
		logic               valid;
		logic [CLASS_W-1:0] cls;
	} class_t;

	// Bytes from space to DEL map to classes from zero up, then CR and LF.
	function automatic class_t byte_class(input logic [7:0] b);
		class_t r;
		r.valid = 1'b1;
		r.cls   = '0;
		if (b >= CHAR_SPACE && b <= CHAR_DEL) begin
			r.cls = CLASS_W'(b - CHAR_SPACE);
		end else if (b == CHAR_CR) begin
			r.cls = CLASS_CR;
		end else if (b == CHAR_LF) begin
			r.cls = CLASS_LF;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/char_class_dfa_step_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_class_dfa_step_core
// Programmable byte stream DFA with character classes and ordered slots.
// ----------------------------------------------------------------------------
//  Port group   Direction  Content
//  s_*          in         op in tuser; table write fields and byte in tdata
//  m_*          out        status in tuser; from, to, echo, accepting in tdata
//  p*           in/out     start state, error state and final mask registers
//
//  The accept cycle issues the memory reads (or performs the table write);
//  the next cycle selects the winning slot, updates the state and loads
//  the output register, and s_tready is low meanwhile.
//  After reset, a clearing pass runs over the 2048-entry class memory;
//  no item is accepted then, configuration writes are.
//  A new item is accepted while the previous result is being taken.
// ----------------------------------------------------------------------------
module char_class_dfa_step_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// char_code[7:0], row_state[11:8], target_state[15:12], slot[18:16],
	// slot_bits[26:19], slot_count[30:27], zero[31]
	input  wire logic [31:0] s_tdata,
	// op[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// source state[3:0], new state[7:4], echo_char[15:8], accepting[16],
	// zero[23:17]
	output logic      [23:0] m_tdata,
	// status[1:0]
	output logic      [1:0]  m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ccds_pkg::*;

	// Configuration registers
	logic [STATE_W-1:0]    start_q;
	logic [STATE_W-1:0]    error_q;
	logic [NUM_STATES-1:0] final_q;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			error_q <= STATE_W'(15);
			final_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_START: start_q <= pwdata[STATE_W-1:0];
				REG_ERROR: error_q <= pwdata[STATE_W-1:0];
				REG_FINAL: final_q <= pwdata[NUM_STATES-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START: prdata = 32'(start_q);
			REG_ERROR: prdata = 32'(error_q);
			REG_FINAL: prdata = 32'(final_q);
			default:   prdata = '0;
		endcase
	end

	// Input fields
	logic [2:0]                 in_op;
	logic [7:0]                 in_char;
	logic [STATE_W-1:0]         in_row;
	logic [STATE_W-1:0]         in_tgt;
	logic [SLOT_W-1:0]          in_slot;
	logic [SLOTS_PER_STATE-1:0] in_bits;
	logic [CNT_W-1:0]           in_cnt;
	class_t                     in_cls;

	assign in_op   = s_tuser;
	assign in_char = s_tdata[7:0];
	assign in_row  = s_tdata[11:8];
	assign in_tgt  = s_tdata[15:12];
	assign in_slot = s_tdata[18:16];
	assign in_bits = s_tdata[26:19];
	assign in_cnt  = s_tdata[30:27];
	assign in_cls  = byte_class(in_char);

	// Control
	fsm_t  state_q, state_d;
	logic  accept;
	logic  clr_busy;
	logic  out_free;

	assign out_free = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = !clr_busy && out_free;
				if (s_tvalid && s_tready) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Stage 1 item registers
	logic [2:0]         op_s1;
	logic [7:0]         char_s1;
	logic [STATE_W-1:0] tgt_s1;
	logic               cls_ok_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= in_op;
			char_s1   <= in_char;
			tgt_s1    <= in_tgt;
			cls_ok_s1 <= in_cls.valid;
		end
	end

	// Current state and row slot counts
	logic [STATE_W-1:0] cur_q;
	logic [CNT_W-1:0]   cnt_q [NUM_STATES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STATES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept && in_op == OP_WCOUNT) begin
			cnt_q[in_row] <= (in_cnt > CNT_W'(SLOTS_PER_STATE)) ?
				CNT_W'(SLOTS_PER_STATE) : in_cnt;
		end
	end

	// Memories
	cmem_wr_t                   cwr;
	tmem_wr_t                   twr;
	logic [SLOTS_PER_STATE-1:0] cls_row;
	tgt_row_t                   tgt_row;
	logic                       step_op;

	assign step_op = in_op == OP_BYTE || in_op == OP_FORCE;

	always_comb begin
		cwr.en   = accept && in_op == OP_WCLASS && in_cls.valid;
		cwr.addr = {in_row, in_cls.cls};
		cwr.data = in_bits;
		twr.en   = accept && in_op == OP_WTARGET;
		twr.row  = in_row;
		twr.slot = in_slot;
		twr.data = in_tgt;
	end

	ccds_class_mem u_class_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cwr),
		.rd_en   (accept && step_op),
		.rd_addr ({cur_q, in_cls.cls}),
		.rd_data (cls_row),
		.busy    (clr_busy)
	);

	ccds_tgt_mem u_tgt_mem (
		.clk     (clk),
		.wr      (twr),
		.rd_en   (accept && step_op),
		.rd_row  (cur_q),
		.rd_data (tgt_row)
	);

	// Slot selection: lowest active matching slot wins.
	logic [SLOTS_PER_STATE-1:0] hits;
	logic                       hit;
	logic [SLOT_W-1:0]          hit_idx;
	logic [CNT_W-1:0]           row_n;

	assign row_n = cnt_q[cur_q];

	always_comb begin
		for (int k = 0; k < SLOTS_PER_STATE; k++) begin
			if (op_s1 == OP_BYTE) begin
				hits[k] = cls_row[k] && (CNT_W'(k) < row_n);
			end else begin
				hits[k] = (tgt_row[k] == tgt_s1) && (CNT_W'(k) < row_n);
			end
		end
		hit     = |hits;
		hit_idx = '0;
		for (int k = SLOTS_PER_STATE - 1; k >= 0; k--) begin
			if (hits[k]) begin
				hit_idx = SLOT_W'(k);
			end
		end
	end

	// Result of the item in execution
	logic [1:0]         res_status;
	logic [STATE_W-1:0] res_to;
	logic [7:0]         res_echo;
	logic               res_upd;

	always_comb begin
		res_status = ST_DONE;
		res_to     = cur_q;
		res_echo   = '0;
		res_upd    = 1'b0;
		case (op_s1)
			OP_BYTE, OP_FORCE: begin
				if (op_s1 == OP_BYTE) begin
					res_echo = char_s1;
				end
				if (op_s1 == OP_BYTE && !cls_ok_s1) begin
					res_status = ST_INVALID;
				end else begin
					res_upd = 1'b1;
					if (hit) begin
						res_status = ST_MATCH;
						res_to     = tgt_row[hit_idx];
					end else begin
						res_status = ST_NOMATCH;
						res_to     = error_q;
					end
				end
			end
			OP_WCLASS: begin
				if (!cls_ok_s1) begin
					res_status = ST_INVALID;
				end
			end
			OP_RESTART: begin
				res_upd = 1'b1;
				res_to  = start_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (state_q == FSM_EXEC && res_upd) begin
			cur_q <= res_to;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == FSM_EXEC) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_EXEC) begin
			m_tuser <= res_status;
			m_tdata <= {7'd0, final_q[res_to], res_echo, res_to, cur_q};
		end
	end

	// Assertions
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("item accepted during clearing pass");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == FSM_EXEC)
		else $error("accepted item not executed next cycle");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_EXEC |=> m_tvalid)
		else $error("executed item produced no result");

	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_EXEC |-> !m_tvalid || m_tready)
		else $error("result register overwritten while still full");

	a_state_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_q) |-> $past(state_q == FSM_EXEC))
		else $error("current state changed outside execution");

endmodule
`default_nettype wire

/* rtl/ccds_class_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccds_class_mem
// Class match memory: one slot match vector per state and class, with a
// clearing pass after reset.
// ----------------------------------------------------------------------------
module ccds_class_mem (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ccds_pkg::cmem_wr_t                  wr,
	input  wire logic                                rd_en,
	input  wire logic [ccds_pkg::CADDR_W-1:0]        rd_addr,
	output logic      [ccds_pkg::SLOTS_PER_STATE-1:0] rd_data,
	output logic                                     busy
);
	import ccds_pkg::*;

	localparam int DEPTH = 2 ** CADDR_W;

	logic [SLOTS_PER_STATE-1:0] mem [DEPTH];
	logic [CADDR_W-1:0]         clr_q;
	logic                       clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == CADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = clearing_q;

endmodule
`default_nettype wire

/* rtl/ccds_tgt_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccds_tgt_mem
// Slot target memory: one row of slot targets per state, written one slot
// at a time and read a whole row at a time.
// ----------------------------------------------------------------------------
module ccds_tgt_mem (
	input  wire logic                         clk,
	input  wire ccds_pkg::tmem_wr_t           wr,
	input  wire logic                         rd_en,
	input  wire logic [ccds_pkg::STATE_W-1:0] rd_row,
	output ccds_pkg::tgt_row_t                rd_data
);
	import ccds_pkg::*;

	tgt_row_t mem [NUM_STATES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row][wr.slot] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule
`default_nettype wire
